>>> rtl/column_trace_centroid_defines.svh
// assertion macros for the column trace centroid block
`ifndef COLUMN_TRACE_CENTROID_DEFINES_SVH
`define COLUMN_TRACE_CENTROID_DEFINES_SVH

`ifndef SYNTHESIS

`define CTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ctc assertion failed");

`define CTC_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ctc assertion failed");

`else

`define CTC_ASSERT(label, clk, rst_n, prop)

`define CTC_ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

>>> rtl/ctc_pkg.sv
package ctc_pkg;

    localparam int PIX_W    = 12;
    localparam int CHAN_W   = 8;
    localparam int SUM_W    = 24;
    localparam int COUNT_W  = 13;
    localparam int HIT_CAP  = 4096;
    localparam int MAX_ROWS = 4096;
    localparam int MAX_COLUMNS = 4096;

    localparam int DIV_STEPS = 12;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_HIGH = 2'd1;

    localparam logic [CHAN_W-1:0] LEVEL_LOW_RESET  = 8'd0;
    localparam logic [CHAN_W-1:0] LEVEL_HIGH_RESET = 8'd50;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_OUTPUT
    } ctc_state_t;

    typedef struct packed {
        logic pix_accept;
        logic div_start;
        logic div_step;
    } ctc_cmd_t;

    typedef struct packed {
        logic has_hits;
    } ctc_status_t;

endpackage

>>> rtl/ctc_ctrl.sv
`include "column_trace_centroid_defines.svh"

module ctc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                column_end,
    input  ctc_pkg::ctc_status_t status,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ctc_pkg::ctc_cmd_t   cmd
);

    ctc_pkg::ctc_state_t             state_reg;
    ctc_pkg::ctc_state_t             state_next;
    logic [ctc_pkg::STEP_W-1:0]      count_reg;
    logic [ctc_pkg::STEP_W-1:0]      count_next;
    logic                            last_step;

    assign last_step = (count_reg == ctc_pkg::STEP_W'(ctc_pkg::DIV_STEPS - 1));
    assign out_valid = (state_reg == ctc_pkg::ST_OUTPUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctc_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ctc_pkg::ST_DIVIDE:
            begin
                in_ready     = !column_end;
                cmd.div_step = 1'b1;
                count_next   = count_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ctc_pkg::ST_OUTPUT;
                end
            end
            ctc_pkg::ST_OUTPUT:
            begin
                in_ready = !column_end;
                if (out_ready)
                begin
                    state_next = ctc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctc_pkg::ST_IDLE;
            end
        endcase
        cmd.pix_accept = in_valid && in_ready;
        cmd.div_start  = cmd.pix_accept && column_end && status.has_hits;
        if (cmd.div_start)
        begin
            state_next = ctc_pkg::ST_DIVIDE;
            count_next = '0;
        end
    end

    // column close only while the divider is free
    `CTC_ASSERT_NEVER(a_end_while_busy, clk, rst_n, cmd.pix_accept && column_end && state_reg != ctc_pkg::ST_IDLE)
    `CTC_ASSERT(a_div_len, clk, rst_n, (cmd.div_step && last_step) |=> out_valid)
    `CTC_ASSERT(a_out_after_div, clk, rst_n, $rose(out_valid) |-> $past(cmd.div_step))
    `CTC_ASSERT_NEVER(a_step_out_excl, clk, rst_n, cmd.div_step && out_valid)

endmodule

>>> rtl/ctc_datapath.sv
module ctc_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ctc_pkg::ctc_cmd_t                    cmd,
    output ctc_pkg::ctc_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ctc_pkg::CHAN_W-1:0]           cfg_data,
    input  logic [ctc_pkg::PIX_W-1:0]            column,
    input  logic [ctc_pkg::PIX_W-1:0]            row,
    input  logic [ctc_pkg::CHAN_W-1:0]           red,
    input  logic [ctc_pkg::CHAN_W-1:0]           green,
    input  logic [ctc_pkg::CHAN_W-1:0]           blue,
    input  logic                                 column_end,
    output logic [ctc_pkg::PIX_W-1:0]            out_column,
    output logic [ctc_pkg::PIX_W-1:0]            mean_row,
    output logic [ctc_pkg::COUNT_W-1:0]          hit_count
);

    logic [ctc_pkg::CHAN_W-1:0]  level_low_reg;
    logic [ctc_pkg::CHAN_W-1:0]  level_high_reg;
    logic [ctc_pkg::SUM_W-1:0]   row_sum_reg;
    logic [ctc_pkg::COUNT_W-1:0] hit_total_reg;

    logic [ctc_pkg::COUNT_W-1:0] rem_reg;
    logic [ctc_pkg::PIX_W-1:0]   quot_reg;
    logic [ctc_pkg::COUNT_W-1:0] divisor_reg;
    logic [ctc_pkg::PIX_W-1:0]   col_reg;

    logic                        in_image;
    logic                        color_ok;
    logic                        trace;
    logic [ctc_pkg::SUM_W-1:0]   sum_add;
    logic [ctc_pkg::COUNT_W-1:0] total_add;
    logic [ctc_pkg::COUNT_W:0]   trial;
    logic [ctc_pkg::COUNT_W:0]   trial_diff;
    logic                        quot_bit;
    logic [ctc_pkg::COUNT_W-1:0] rem_next;

    assign in_image = (32'(row) < 32'(ctc_pkg::MAX_ROWS))
                   && (32'(column) < 32'(ctc_pkg::MAX_COLUMNS));
    assign color_ok = (red >= level_low_reg) && (red <= level_high_reg)
                   && (green >= level_low_reg) && (green <= level_high_reg)
                   && (blue >= level_low_reg) && (blue <= level_high_reg);
    assign trace = in_image && color_ok
                && (hit_total_reg < ctc_pkg::COUNT_W'(ctc_pkg::HIT_CAP));
    assign sum_add   = row_sum_reg + (trace ? ctc_pkg::SUM_W'(row) : '0);
    assign total_add = hit_total_reg + ctc_pkg::COUNT_W'(trace);
    assign status.has_hits = (total_add != '0);

    // one restoring step, remainder stays below the divisor
    assign trial      = {rem_reg, quot_reg[ctc_pkg::PIX_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign quot_bit   = (trial >= {1'b0, divisor_reg});
    assign rem_next   = quot_bit ? trial_diff[ctc_pkg::COUNT_W-1:0]
                                 : trial[ctc_pkg::COUNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_low_reg  <= ctc_pkg::LEVEL_LOW_RESET;
            level_high_reg <= ctc_pkg::LEVEL_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctc_pkg::REG_LEVEL_LOW:  level_low_reg  <= cfg_data;
                ctc_pkg::REG_LEVEL_HIGH: level_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg   <= '0;
            hit_total_reg <= '0;
        end
        else if (cmd.pix_accept)
        begin
            if (column_end)
            begin
                row_sum_reg   <= '0;
                hit_total_reg <= '0;
            end
            else
            begin
                row_sum_reg   <= sum_add;
                hit_total_reg <= total_add;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg     <= ctc_pkg::COUNT_W'(sum_add[ctc_pkg::SUM_W-1:ctc_pkg::PIX_W]);
            quot_reg    <= sum_add[ctc_pkg::PIX_W-1:0];
            divisor_reg <= total_add;
            col_reg     <= column;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[ctc_pkg::PIX_W-2:0], quot_bit};
        end
    end

    assign out_column = col_reg;
    assign mean_row   = quot_reg;
    assign hit_count  = divisor_reg;

endmodule

>>> rtl/column_trace_centroid.sv
// throughput: one pixel per cycle; a column-end pixel waits while the
// restoring divider runs or an earlier result is not yet taken
// reset: asynchronous active low; levels return to 0 and 50, sums clear
module column_trace_centroid (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ctc_pkg::PIX_W-1:0]            column,
    input  logic [ctc_pkg::PIX_W-1:0]            row,
    input  logic [ctc_pkg::CHAN_W-1:0]           red,
    input  logic [ctc_pkg::CHAN_W-1:0]           green,
    input  logic [ctc_pkg::CHAN_W-1:0]           blue,
    input  logic                                 column_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ctc_pkg::PIX_W-1:0]            out_column,
    output logic [ctc_pkg::PIX_W-1:0]            mean_row,
    output logic [ctc_pkg::COUNT_W-1:0]          hit_count,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ctc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ctc_pkg::CHAN_W-1:0]           cfg_data
);

    ctc_pkg::ctc_cmd_t    cmd;
    ctc_pkg::ctc_status_t status;
    logic                 cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    ctc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .column_end (column_end),
        .status     (status),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    ctc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .column     (column),
        .row        (row),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .column_end (column_end),
        .out_column (out_column),
        .mean_row   (mean_row),
        .hit_count  (hit_count)
    );

endmodule
